### design/ewd_pkg.sv
// Shared types and constants of the equal-width discretizer.
package ewd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int VALUE_W      = 16;
  localparam int RES_W        = 8;
  localparam int PROD_W       = SAMPLE_WIDTH + RES_W;
  localparam int STEP_W       = $clog2(RES_W);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RES_W-1:0] RES_RESET = RES_W'(10);
  localparam logic [RES_W-1:0] RES_MIN   = RES_W'(2);

  // Configuration register indexes
  localparam logic CFG_IDX_RESOLUTION = 1'b0;
  localparam logic CFG_IDX_ENABLE     = 1'b1;

  // Request modes; the unused code is ignored
  typedef enum logic [1:0] {
    MODE_OBSERVE  = 2'd0,
    MODE_CLASSIFY = 2'd1,
    MODE_RESTART  = 2'd2
  } mode_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic                    direct;
    logic                    binned;
    logic [VALUE_W-1:0]      value;
    logic [SAMPLE_WIDTH-1:0] diff;
    logic [SAMPLE_WIDTH-1:0] span;
    logic [RES_W-1:0]        res;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_CHK,
    B_DIV,
    B_FIN
  } bstate_t;

endpackage

### design/ewd_in_if.sv
// Request channel: mode and sample with valid/ready.
interface ewd_in_if;
  import ewd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

### design/ewd_out_if.sv
// Result channel: value and was_binned with valid/ready.
interface ewd_out_if;
  import ewd_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               was_binned;

  modport source (output valid, output value, output was_binned, input ready);
  modport sink   (input valid, input value, input was_binned, output ready);
endinterface

### design/ewd_front.sv
// Front end: configuration, running statistics and request classification.
module ewd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  ewd_in_if.sink                     in_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ewd_pkg::RES_W-1:0]  cfg_wdata,
  input  ewd_pkg::q_stat_t           q_stat,
  output logic                       push,
  output ewd_pkg::job_t              push_job
);
  import ewd_pkg::*;

  logic [RES_W-1:0]        res_r;
  logic                    en_r;
  logic [SAMPLE_WIDTH-1:0] min_r, min_nxt;
  logic [SAMPLE_WIDTH-1:0] max_r, max_nxt;
  logic                    have_r, have_nxt;

  logic                    accept;
  mode_t                   md;
  logic [SAMPLE_WIDTH-1:0] s;
  logic [RES_W-1:0]        res_c;
  logic [SAMPLE_WIDTH-1:0] span;
  logic                    below_min;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign md          = mode_t'(in_ch.mode);
  assign s           = in_ch.sample;
  assign res_c       = (res_r < RES_MIN) ? RES_MIN : res_r;
  assign span        = max_r - min_r;
  assign below_min   = s < min_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= RES_RESET;
      en_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_RESOLUTION: res_r <= cfg_wdata;
        CFG_IDX_ENABLE:     en_r  <= cfg_wdata[0];
        default:            res_r <= res_r;
      endcase
    end
  end

  // Fold observations into the running range, clear on restart
  always_comb begin
    min_nxt  = min_r;
    max_nxt  = max_r;
    have_nxt = have_r;
    if (accept) begin
      unique case (md)
        MODE_OBSERVE: begin
          if (below_min) min_nxt = s;
          if (s > max_r) max_nxt = s;
          have_nxt = 1'b1;
        end
        MODE_RESTART: begin
          min_nxt  = '1;
          max_nxt  = '0;
          have_nxt = 1'b0;
        end
        default: have_nxt = have_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= '1;
      max_r  <= '0;
      have_r <= 1'b0;
    end else begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      have_r <= have_nxt;
    end
  end

  // Classify: pass through, fixed top bin, or hand off to the divider
  always_comb begin
    push_job.direct = 1'b1;
    push_job.binned = 1'b0;
    push_job.value  = VALUE_W'(s);
    push_job.diff   = s - min_r;
    push_job.span   = span;
    push_job.res    = res_c;
    if (en_r && have_r && !below_min) begin
      push_job.binned = 1'b1;
      if (max_r < min_r || span == '0) begin
        push_job.value = {{(VALUE_W-RES_W){1'b0}}, res_c} - VALUE_W'(1);
      end else begin
        push_job.direct = 1'b0;
      end
    end
  end

  assign push = accept && (md == MODE_CLASSIFY);

endmodule

### design/ewd_fifo.sv
// Short request queue between the front and the back.
module ewd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ewd_pkg::job_t    push_job,
  input  logic             pop,
  output ewd_pkg::job_t    pop_job,
  output ewd_pkg::q_stat_t q_stat
);
  import ewd_pkg::*;

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign pop_job      = mem[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + QUEUE_CW'(1);
        2'b01:   count_r <= count_r - QUEUE_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");

endmodule

### design/ewd_back.sv
// Back end: multiply, bounded restoring division and result register.
module ewd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ewd_pkg::job_t    pop_job,
  input  ewd_pkg::q_stat_t q_stat,
  output logic             pop,
  ewd_out_if.source        out_ch
);
  import ewd_pkg::*;

  bstate_t                 st_r, st_nxt;
  logic [SAMPLE_WIDTH-1:0] diff_r, diff_nxt;
  logic [SAMPLE_WIDTH-1:0] span_r, span_nxt;
  logic [RES_W-1:0]        res_r, res_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [SAMPLE_WIDTH-1:0] rem_r, rem_nxt;
  logic [RES_W-1:0]        quo_r, quo_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]      out_value_r, out_value_nxt;
  logic                    out_binned_r, out_binned_nxt;

  logic                    out_free;
  logic                    out_load;
  logic                    saturate;
  logic [SAMPLE_WIDTH:0]   trial;
  logic                    qbit;
  logic [RES_W-1:0]        res_m2;
  logic [RES_W-1:0]        k;

  assign out_free = !out_valid_r || out_ch.ready;
  assign saturate = prod_r >= {span_r, {RES_W{1'b0}}};
  assign trial    = {rem_r, prod_r[PROD_W-1]};
  assign qbit     = trial >= {1'b0, span_r};
  assign res_m2   = res_r - RES_MIN;
  assign k        = (quo_r > res_m2) ? res_m2 : quo_r;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (!q_stat.empty && !pop_job.direct) st_nxt = B_MUL;
      B_MUL:  st_nxt = B_CHK;
      B_CHK:  st_nxt = saturate ? B_FIN : B_DIV;
      B_DIV:  if (step_r == '0) st_nxt = B_FIN;
      B_FIN:  if (out_free) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    pop            = 1'b0;
    out_load       = 1'b0;
    out_value_nxt  = out_value_r;
    out_binned_nxt = out_binned_r;
    diff_nxt       = diff_r;
    span_nxt       = span_r;
    res_nxt        = res_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    unique case (st_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          if (pop_job.direct) begin
            // Finished already: forward when the result register frees
            if (out_free) begin
              pop            = 1'b1;
              out_load       = 1'b1;
              out_value_nxt  = pop_job.value;
              out_binned_nxt = pop_job.binned;
            end
          end else begin
            pop      = 1'b1;
            diff_nxt = pop_job.diff;
            span_nxt = pop_job.span;
            res_nxt  = pop_job.res;
          end
        end
      end
      B_MUL: begin
        prod_nxt = PROD_W'(diff_r) * PROD_W'(res_r);
      end
      B_CHK: begin
        // Quotient of 256 or more clamps anyway
        if (saturate) begin
          quo_nxt = '1;
        end else begin
          rem_nxt  = prod_r[PROD_W-1:RES_W];
          prod_nxt = {prod_r[RES_W-1:0], {SAMPLE_WIDTH{1'b0}}};
          quo_nxt  = '0;
          step_nxt = STEP_W'(RES_W - 1);
        end
      end
      B_DIV: begin
        // One quotient bit per cycle
        rem_nxt  = qbit ? SAMPLE_WIDTH'(trial - {1'b0, span_r})
                        : trial[SAMPLE_WIDTH-1:0];
        quo_nxt  = {quo_r[RES_W-2:0], qbit};
        prod_nxt = {prod_r[PROD_W-2:0], 1'b0};
        step_nxt = step_r - STEP_W'(1);
      end
      B_FIN: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_value_nxt  = {{(VALUE_W-RES_W){1'b0}}, k} + VALUE_W'(1);
          out_binned_nxt = 1'b1;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r       <= diff_nxt;
    span_r       <= span_nxt;
    res_r        <= res_nxt;
    prod_r       <= prod_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    out_value_r  <= out_value_nxt;
    out_binned_r <= out_binned_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.was_binned = out_binned_r;

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_DIV |-> rem_r < span_r)
    else $error("partial remainder reached the range");

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && st_r == B_FIN |-> out_value_nxt != '0 &&
      out_value_nxt < {{(VALUE_W-RES_W){1'b0}}, res_r})
    else $error("bin number outside 1 .. resolution-1");

  a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_FIN && $past(st_r) != B_FIN |->
      $past(st_r) == B_DIV || $past(st_r) == B_CHK)
    else $error("result stage entered without a division");

endmodule

### design/equal_width_discretizer_unit.sv
// Equal-width discretizer: front end, request queue and division back end.
// Observe and restart requests give no result.
// A classify request that needs a division passes through the queue, the multiply,
// the range check and the 8-step restoring divider before it reaches the result register;
// a product that saturates the quotient skips the divider, and other classify results
// go from the queue straight to the result register. Divisions run one at a time.
// Reset (synchronous, rst_n low): range empty, no observation, resolution 10, binning on.
module equal_width_discretizer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  ewd_in_if.sink                    in_ch,
  ewd_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ewd_pkg::RES_W-1:0] cfg_wdata
);
  import ewd_pkg::*;

  logic    push, pop;
  job_t    push_job, pop_job;
  q_stat_t q_stat;

  ewd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  ewd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  ewd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .pop_job (pop_job),
    .q_stat  (q_stat),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

### dv/tb_equal_width_discretizer_unit.sv
// Self-checking testbench of the equal-width discretizer: directed table, then random phases.
`timescale 1ns / 100ps

module tb_equal_width_discretizer_unit;
  import ewd_pkg::*;

  localparam int          CLK_HALF     = 5;
  localparam int          RESET_CYCLES = 12;
  localparam int          SETTLE_CYC   = 20;
  localparam int          ITEM_TARGET  = 1450;
  localparam int          PHASE_ITEMS  = 120;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               was_binned;
  } bin_result_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [1:0]              mode;
    logic [SAMPLE_WIDTH-1:0] data;
    logic                    fixed;
    logic [VALUE_W-1:0]      fixed_value;
    logic                    fixed_binned;
    logic                    cfg_idx;
  } dir_row_t;

  // Directed requests; fixed rows carry the result typed in by hand
  localparam int DIR_ROWS = 25;
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_REQ, MODE_CLASSIFY, 16'd1234,  1'b1, 16'd1234, 1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_UNUSED,   16'hFFFF,  1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_OBSERVE,  16'd100,   1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'd100,   1'b1, 16'd9,    1'b1, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'd50,    1'b1, 16'd50,   1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_OBSERVE,  16'd1100,  1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'd100,   1'b1, 16'd1,    1'b1, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'd600,   1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'd1100,  1'b1, 16'd9,    1'b1, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'hFFFF,  1'b1, 16'd9,    1'b1, CFG_IDX_RESOLUTION},
    '{ROW_CFG, MODE_OBSERVE,  16'd0,     1'b0, 16'd0,    1'b0, CFG_IDX_ENABLE},
    '{ROW_REQ, MODE_CLASSIFY, 16'd600,   1'b1, 16'd600,  1'b0, CFG_IDX_RESOLUTION},
    '{ROW_CFG, MODE_OBSERVE,  16'd1,     1'b0, 16'd0,    1'b0, CFG_IDX_ENABLE},
    '{ROW_CFG, MODE_OBSERVE,  16'd0,     1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'd600,   1'b1, 16'd1,    1'b1, CFG_IDX_RESOLUTION},
    '{ROW_CFG, MODE_OBSERVE,  16'd255,   1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'd1099,  1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_RESTART,  16'd0,     1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'd600,   1'b1, 16'd600,  1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_OBSERVE,  16'd0,     1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_OBSERVE,  16'hFFFF,  1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'hFFFF,  1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'h8000,  1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_CFG, MODE_OBSERVE,  16'd1,     1'b0, 16'd0,    1'b0, CFG_IDX_RESOLUTION},
    '{ROW_REQ, MODE_CLASSIFY, 16'd0,     1'b1, 16'd1,    1'b1, CFG_IDX_RESOLUTION}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [RES_W-1:0] cfg_wdata;

  ewd_in_if  in_ch ();
  ewd_out_if out_ch ();

  equal_width_discretizer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the block's statistics and registers
  logic [SAMPLE_WIDTH-1:0] stat_min;
  logic [SAMPLE_WIDTH-1:0] stat_max;
  logic                    stat_seen;
  logic [RES_W-1:0]        res_reg;
  logic                    enable_reg;

  bin_result_t expected_bins [$];
  bin_result_t want;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned gap_max;
  int unsigned stall_max;
  int unsigned obs_base;
  int unsigned obs_width;

  always #(CLK_HALF) clk = ~clk;

  // Bin number of a sample that is not below the running minimum
  function automatic logic [VALUE_W-1:0] bin_of(logic [SAMPLE_WIDTH-1:0] smp);
    int unsigned res;
    int unsigned span;
    int unsigned offs;
    int unsigned k;
    res = 32'((res_reg < RES_MIN) ? RES_MIN : res_reg);
    span = 32'(stat_max);
    span = span - 32'(stat_min);
    if (stat_max < stat_min || span == 0) return VALUE_W'(res - 1);
    offs = 32'(smp);
    offs = offs - 32'(stat_min);
    k = (offs * res) / span;
    if (k > res - 2) k = res - 2;
    return VALUE_W'(k + 1);
  endfunction

  // Advance the statistics for one request and work out its result
  task automatic apply_request(input logic [1:0] mode, input logic [SAMPLE_WIDTH-1:0] smp,
                               output bit has_res, output bin_result_t r);
    has_res = 1'b0;
    r = '0;
    case (mode_t'(mode))
      MODE_OBSERVE: begin
        if (smp < stat_min) stat_min = smp;
        if (smp > stat_max) stat_max = smp;
        stat_seen = 1'b1;
      end
      MODE_RESTART: begin
        stat_min  = '1;
        stat_max  = '0;
        stat_seen = 1'b0;
      end
      MODE_CLASSIFY: begin
        has_res = 1'b1;
        if (!enable_reg || !stat_seen || smp < stat_min) begin
          r.value      = smp;
          r.was_binned = 1'b0;
        end else begin
          r.value      = bin_of(smp);
          r.was_binned = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Drive one request after a random gap and record what it should produce
  task automatic send_request(input logic [1:0] mode, input logic [SAMPLE_WIDTH-1:0] smp,
                              input bit use_fixed, input bin_result_t fixed_res);
    int unsigned gap;
    bit          has_res;
    bin_result_t pred;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(mode, smp, has_res, pred);
    if (has_res) expected_bins.insert(expected_bins.size(), use_fixed ? fixed_res : pred);
  endtask

  // Hold off requests until every result is back and the divider is quiet
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bins.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [RES_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == CFG_IDX_RESOLUTION) res_reg = data;
    else enable_reg = data[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pick a new cluster for observed samples, from a single point to the full range
  task automatic pick_cluster();
    obs_base = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16'hFFFF);
    case ($urandom_range(0, 3))
      0: obs_width = 0;
      1: obs_width = $urandom_range(1, 16);
      2: obs_width = $urandom_range(17, 4096);
      default: obs_width = $urandom_range(0, 16'hFFFF);
    endcase
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] draw_observe();
    int unsigned v;
    v = obs_base + $urandom_range(0, obs_width);
    if (v > 16'hFFFF) v = 16'hFFFF;
    return SAMPLE_WIDTH'(v);
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] draw_classify();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (stat_seen && pick < 6) return SAMPLE_WIDTH'($urandom_range(stat_min, stat_max));
    if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return stat_min - 1'b1;
        default: return stat_max + 1'b1;
      endcase
    end
    return SAMPLE_WIDTH'($urandom_range(0, 16'hFFFF));
  endfunction

  // Result side: stall a random number of cycles before each result
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bins.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with nothing expected: value=%0d was_binned=%0b",
                   $realtime, out_ch.value, out_ch.was_binned);
      end else begin
        want = expected_bins.pop_front();
        if (out_ch.value !== want.value || out_ch.was_binned !== want.was_binned) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch: expected value=%0d was_binned=%0b, %s",
                     $realtime, want.value, want.was_binned,
                     $sformatf("got value=%0d was_binned=%0b",
                               out_ch.value, out_ch.was_binned));
        end
      end
    end
  end

  // Watchdog on the whole run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned     sent;
    int unsigned     phase;
    int unsigned     in_phase;
    int unsigned     pick;
    logic [1:0]      mode;
    logic [RES_W-1:0] res_w;
    logic [RES_W-1:0] en_w;
    bin_result_t     fixed_res;

    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_IDX_RESOLUTION;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_OBSERVE;
    in_ch.sample   = '0;
    mismatch_count = 0;
    gap_max        = 19;
    stall_max      = 19;
    stat_min       = '1;
    stat_max       = '0;
    stat_seen      = 1'b0;
    res_reg        = RES_RESET;
    enable_reg     = 1'b1;
    pick_cluster();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain();
        write_cfg(directed_rows[i].cfg_idx, directed_rows[i].data[RES_W-1:0]);
      end else begin
        fixed_res.value      = directed_rows[i].fixed_value;
        fixed_res.was_binned = directed_rows[i].fixed_binned;
        send_request(directed_rows[i].mode, directed_rows[i].data,
                     directed_rows[i].fixed, fixed_res);
      end
    end

    // Random phases, each under its own register setting and idling pattern
    sent  = 0;
    phase = 0;
    while (sent < ITEM_TARGET) begin
      drain();
      case (phase)
        0: res_w = RES_MIN;
        1: res_w = 8'd255;
        2: res_w = 8'd0;
        3: res_w = 8'd1;
        default: res_w = RES_W'(($urandom_range(0, 3) == 0) ? $urandom_range(3, 8)
                                                            : $urandom_range(2, 255));
      endcase
      en_w = RES_W'($urandom_range(0, 255));
      en_w[0] = (phase % 5 != 4);
      write_cfg(CFG_IDX_RESOLUTION, res_w);
      write_cfg(CFG_IDX_ENABLE, en_w);

      case (phase % 3)
        0: begin
          gap_max   = 0;
          stall_max = 0;
        end
        1: begin
          gap_max   = 19;
          stall_max = 19;
        end
        default: begin
          gap_max   = $urandom_range(0, 1) ? 19 : 0;
          stall_max = (gap_max == 0) ? 19 : 0;
        end
      endcase

      pick_cluster();
      if ($urandom_range(0, 1)) begin
        send_request(MODE_RESTART, SAMPLE_WIDTH'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
        sent++;
      end

      in_phase = 0;
      while (in_phase < PHASE_ITEMS && sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          mode = MODE_RESTART;
          pick_cluster();
        end else if (pick < 7) mode = MODE_UNUSED;
        else if (pick < 37) mode = MODE_OBSERVE;
        else mode = MODE_CLASSIFY;

        case (mode)
          MODE_OBSERVE:  send_request(mode, draw_observe(), 1'b0, '0);
          MODE_CLASSIFY: send_request(mode, draw_classify(), 1'b0, '0);
          default:       send_request(mode, SAMPLE_WIDTH'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
        endcase
        if (mode != MODE_UNUSED) begin
          in_phase++;
          sent++;
        end

        // Now and then let the pipeline run dry mid-phase
        if ($urandom_range(0, 99) == 0) drain();
      end
      phase++;
    end

    drain();
    mismatch_count += expected_bins.size();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
